// ===== sv/ctfe_pkg.sv =====
// ctfe_pkg: types and constants shared by the cascaded fir equalizer modules
// no dependencies; compile first
package ctfe_pkg;

   localparam int DATA_W = 32;
   localparam int IDX_W  = 6;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [1:0] {
      CTFE_SAMPLE,
      CTFE_COEF_WR,
      CTFE_COEF_SKIP
   } ctfe_kind_type;

   typedef enum logic [1:0] {
      CTFE_IDLE,
      CTFE_RUN,
      CTFE_DRAIN,
      CTFE_OUT
   } ctfe_state_type;

   typedef enum logic [1:0] {
      CTFE_STG_LOW,
      CTFE_STG_MID,
      CTFE_STG_HIGH
   } ctfe_stage_type;

   typedef struct packed {
      logic [3:0] keep;
      logic [3:0] strobe;
      logic       last;
      logic       id;
      logic       dest;
      logic       user;
   } ctfe_side_type;

   typedef struct packed {
      ctfe_kind_type            kind;
      logic [IDX_W-1:0]         coef_index;
      logic signed [DATA_W-1:0] coef_value;
      logic signed [DATA_W-1:0] sample;
      ctfe_side_type            side;
   } ctfe_item_type;

   typedef struct packed {
      logic load;
      logic shift;
   } ctfe_dl_ctl_type;

endpackage

// ===== sv/ctfe_front.sv =====
// ctfe_front: unpacks request transactions and classifies them for the queue
// depends on ctfe_pkg
module ctfe_front #(
   parameter int TABLE_SIZE = 63
) (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ctfe_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tlast,
   input  logic                              req_tuser,
   output logic                              push,
   input  logic                              q_ready,
   output ctfe_pkg::ctfe_item_type           item
);

   logic [ctfe_pkg::IDX_W-1:0] idx;
   logic                       in_range;

   assign idx      = req_tdata[5:0];
   assign in_range = ({26'd0, idx} < 32'(TABLE_SIZE));

   always_comb begin
      if (!req_tuser) begin
         item.kind = ctfe_pkg::CTFE_SAMPLE;
      end else if (in_range) begin
         item.kind = ctfe_pkg::CTFE_COEF_WR;
      end else begin
         item.kind = ctfe_pkg::CTFE_COEF_SKIP;
      end
      item.coef_index  = idx;
      item.coef_value  = req_tdata[37:6];
      item.sample      = req_tdata[69:38];
      item.side.keep   = req_tdata[73:70];
      item.side.strobe = req_tdata[77:74];
      item.side.last   = req_tlast;
      item.side.id     = req_tdata[78];
      item.side.dest   = req_tdata[79];
      item.side.user   = req_tdata[80];
   end

   assign req_tready = q_ready;
   assign push       = req_tvalid & q_ready;

endmodule

// ===== sv/ctfe_fifo.sv =====
// ctfe_fifo: two-entry queue of classified items between front and back
// depends on ctfe_pkg
module ctfe_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ctfe_pkg::ctfe_item_type push_item,
   output logic                    not_full,
   input  logic                    pop,
   output logic                    not_empty,
   output ctfe_pkg::ctfe_item_type pop_item
);

   ctfe_pkg::ctfe_item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/ctfe_dline.sv =====
// ctfe_dline: one fir delay line, rotated through a fixed read tap during the mac pass
// depends on ctfe_pkg
module ctfe_dline #(
   parameter int DEPTH = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ctfe_pkg::ctfe_dl_ctl_type         ctl,
   input  logic [ctfe_pkg::DATA_W-1:0]       x,
   output logic [ctfe_pkg::DATA_W-1:0]       head
);

   logic [ctfe_pkg::DATA_W-1:0] line_ff [DEPTH];
   logic [ctfe_pkg::DATA_W-1:0] carry_ff;

   assign head = line_ff[0];

   // pop head, push carry at tail; carry starts as the new input so the
   // line ends up shifted by one with the oldest entry dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            line_ff[i] <= '0;
         end
      end else if (ctl.shift) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            line_ff[i] <= line_ff[i+1];
         end
         line_ff[DEPTH-1] <= carry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         carry_ff <= x;
      end else if (ctl.shift) begin
         carry_ff <= line_ff[0];
      end
   end

endmodule

// ===== sv/ctfe_back.sv =====
// ctfe_back: coefficient table, tap sequencer, multiply-accumulate and result register
// depends on ctfe_pkg and ctfe_dline
module ctfe_back #(
   parameter int LOW_TAPS  = 21,
   parameter int MID_TAPS  = 21,
   parameter int HIGH_TAPS = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  ctfe_pkg::ctfe_item_type           q_item,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ctfe_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int TABLE_SIZE = LOW_TAPS + MID_TAPS + HIGH_TAPS;
   localparam int TW = $clog2(TABLE_SIZE);

   ctfe_pkg::ctfe_state_type state_ff, state_in;
   ctfe_pkg::ctfe_stage_type stage_ff, stage_in;
   logic [TW-1:0] tap_ff, tap_in;
   logic [TW-1:0] addr_ff, addr_in;
   logic [TW-1:0] stage_last;

   logic [ctfe_pkg::DATA_W-1:0] coef_mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0]       coef_vld_ff;
   logic [ctfe_pkg::DATA_W-1:0] coef_rd_ff;
   logic                        rd_vld_ff;
   logic [ctfe_pkg::DATA_W-1:0] coef_q;
   logic [TW-1:0]               wr_addr;

   logic [ctfe_pkg::DATA_W-1:0] x_ff, x_in;
   ctfe_pkg::ctfe_side_type     side_ff;
   logic [ctfe_pkg::DATA_W-1:0] opnd_ff, opnd_in;
   logic [ctfe_pkg::DATA_W-1:0] prod_ff;
   logic [ctfe_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic p1_vld_ff, p1_first_ff, p1_last_ff;
   logic p2_vld_ff, p2_first_ff, p2_last_ff;

   logic issue, issue_last, pop, mem_we, stage_done, load_rsp;

   logic [ctfe_pkg::DATA_W-1:0] head_lo, head_mid, head_hi;
   ctfe_pkg::ctfe_dl_ctl_type   ctl_lo, ctl_mid, ctl_hi;

   logic                        rsp_vld_ff;
   logic [ctfe_pkg::DATA_W-1:0] rsp_data_ff;
   ctfe_pkg::ctfe_side_type     rsp_side_ff;

   always_comb begin
      case (stage_ff)
         ctfe_pkg::CTFE_STG_LOW:  stage_last = TW'(LOW_TAPS - 1);
         ctfe_pkg::CTFE_STG_MID:  stage_last = TW'(MID_TAPS - 1);
         ctfe_pkg::CTFE_STG_HIGH: stage_last = TW'(HIGH_TAPS - 1);
         default:                 stage_last = TW'(HIGH_TAPS - 1);
      endcase
   end

   assign stage_done = p2_vld_ff & p2_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctfe_pkg::CTFE_IDLE: begin
            if (q_valid && q_item.kind == ctfe_pkg::CTFE_SAMPLE) begin
               state_in = ctfe_pkg::CTFE_RUN;
            end
         end
         ctfe_pkg::CTFE_RUN: begin
            if (tap_ff == stage_last) begin
               state_in = ctfe_pkg::CTFE_DRAIN;
            end
         end
         ctfe_pkg::CTFE_DRAIN: begin
            if (stage_done) begin
               state_in = (stage_ff == ctfe_pkg::CTFE_STG_HIGH) ?
                          ctfe_pkg::CTFE_OUT : ctfe_pkg::CTFE_RUN;
            end
         end
         ctfe_pkg::CTFE_OUT: begin
            if (!rsp_vld_ff || rsp_tready) begin
               state_in = ctfe_pkg::CTFE_IDLE;
            end
         end
         default: state_in = ctfe_pkg::CTFE_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop        = (state_ff == ctfe_pkg::CTFE_IDLE) && q_valid;
      issue      = (state_ff == ctfe_pkg::CTFE_RUN);
      issue_last = issue && (tap_ff == stage_last);
      mem_we     = pop && (q_item.kind == ctfe_pkg::CTFE_COEF_WR);
      load_rsp   = (state_ff == ctfe_pkg::CTFE_OUT) && (!rsp_vld_ff || rsp_tready);
      tap_in     = tap_ff;
      addr_in    = addr_ff;
      stage_in   = stage_ff;
      x_in       = x_ff;
      if (pop) begin
         tap_in   = '0;
         addr_in  = '0;
         stage_in = ctfe_pkg::CTFE_STG_LOW;
         x_in     = q_item.sample;
      end else if (issue) begin
         tap_in  = tap_ff + 1'b1;
         addr_in = addr_ff + 1'b1;
      end else if (state_ff == ctfe_pkg::CTFE_DRAIN && stage_done) begin
         tap_in = '0;
         x_in   = acc_in;
         case (stage_ff)
            ctfe_pkg::CTFE_STG_LOW: stage_in = ctfe_pkg::CTFE_STG_MID;
            ctfe_pkg::CTFE_STG_MID: stage_in = ctfe_pkg::CTFE_STG_HIGH;
            default:                stage_in = stage_ff;
         endcase
      end
   end

   assign q_pop = pop;

   // delay line controls and operand select
   always_comb begin
      ctl_lo  = '0;
      ctl_mid = '0;
      ctl_hi  = '0;
      case (stage_ff)
         ctfe_pkg::CTFE_STG_LOW: begin
            ctl_lo.load  = issue && (tap_ff == '0);
            ctl_lo.shift = issue && (tap_ff != '0);
            opnd_in      = head_lo;
         end
         ctfe_pkg::CTFE_STG_MID: begin
            ctl_mid.load  = issue && (tap_ff == '0);
            ctl_mid.shift = issue && (tap_ff != '0);
            opnd_in       = head_mid;
         end
         default: begin
            ctl_hi.load  = issue && (tap_ff == '0);
            ctl_hi.shift = issue && (tap_ff != '0);
            opnd_in      = head_hi;
         end
      endcase
      if (tap_ff == '0) begin
         opnd_in = x_ff;
      end
   end

   ctfe_dline #(.DEPTH(LOW_TAPS - 1)) u_dl_lo (
      .clock(clock), .reset(reset), .ctl(ctl_lo), .x(x_ff), .head(head_lo)
   );
   ctfe_dline #(.DEPTH(MID_TAPS - 1)) u_dl_mid (
      .clock(clock), .reset(reset), .ctl(ctl_mid), .x(x_ff), .head(head_mid)
   );
   ctfe_dline #(.DEPTH(HIGH_TAPS - 1)) u_dl_hi (
      .clock(clock), .reset(reset), .ctl(ctl_hi), .x(x_ff), .head(head_hi)
   );

   // coefficient table; entries never written read as zero
   assign wr_addr = TW'(q_item.coef_index);
   assign coef_q  = rd_vld_ff ? coef_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         coef_mem[wr_addr] <= q_item.coef_value;
      end
      coef_rd_ff <= coef_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (mem_we) begin
            coef_vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= coef_vld_ff[addr_ff];
      end
   end

   assign acc_in = p2_first_ff ? prod_ff : acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
      prod_ff <= ctfe_pkg::DATA_W'(opnd_ff * coef_q);
      x_ff    <= x_in;
      if (p2_vld_ff) begin
         acc_ff <= acc_in;
      end
      if (pop) begin
         side_ff <= q_item.side;
      end
      if (load_rsp) begin
         rsp_data_ff <= acc_ff;
         rsp_side_ff <= side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ctfe_pkg::CTFE_IDLE;
         stage_ff    <= ctfe_pkg::CTFE_STG_LOW;
         tap_ff      <= '0;
         addr_ff     <= '0;
         p1_vld_ff   <= 1'b0;
         p1_first_ff <= 1'b0;
         p1_last_ff  <= 1'b0;
         p2_vld_ff   <= 1'b0;
         p2_first_ff <= 1'b0;
         p2_last_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         stage_ff    <= stage_in;
         tap_ff      <= tap_in;
         addr_ff     <= addr_in;
         p1_vld_ff   <= issue;
         p1_first_ff <= issue && (tap_ff == '0);
         p1_last_ff  <= issue_last;
         p2_vld_ff   <= p1_vld_ff;
         p2_first_ff <= p1_first_ff;
         p2_last_ff  <= p1_last_ff;
         if (load_rsp) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = rsp_side_ff.last;
   assign rsp_tdata  = {5'd0, rsp_side_ff.user, rsp_side_ff.dest, rsp_side_ff.id,
                        rsp_side_ff.strobe, rsp_side_ff.keep, rsp_data_ff};

endmodule

// ===== sv/cascaded_three_fir_equalizer_unit.sv =====
// cascaded_three_fir_equalizer_unit: low, mid and high fir stages in series
// depends on ctfe_pkg, ctfe_front, ctfe_fifo, ctfe_back
//
//   channel  direction  accepted when            carries
//   req_     in         req_tvalid & req_tready  sample or coefficient write
//   rsp_     out        rsp_tvalid & rsp_tready  filtered sample and sideband
//
// a sample is popped from the queue; then each stage does one multiply-accumulate
// per tap through a single multiplier and drains the mac pipeline; then the result
// register is loaded. a coefficient write is only popped and written to the table.
// reset is synchronous and clears delay lines and the valid bits of the table.
// a two-entry queue takes requests while the back end is busy or stalled, until it is full
module cascaded_three_fir_equalizer_unit #(
   parameter int LOW_TAPS  = 21,
   parameter int MID_TAPS  = 21,
   parameter int HIGH_TAPS = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [5:0] coef_index, [37:6] coef_value, [69:38] sample, [73:70] byte_keep,
   // [77:74] byte_strobe, [78] stream_id, [79] stream_dest, [80] stream_user
   input  logic [ctfe_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tlast,   // last_in
   input  logic                              req_tuser,   // [0] mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] filtered, [35:32] keep_out, [39:36] strobe_out, [40] id_out,
   // [41] dest_out, [42] user_out
   output logic [ctfe_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast    // last_out
);

   localparam int TABLE_SIZE = LOW_TAPS + MID_TAPS + HIGH_TAPS;

   logic                    push, q_ready, q_valid, q_pop;
   ctfe_pkg::ctfe_item_type push_item, q_item;

   ctfe_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .push      (push),
      .q_ready   (q_ready),
      .item      (push_item)
   );

   ctfe_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .not_full (q_ready),
      .pop      (q_pop),
      .not_empty(q_valid),
      .pop_item (q_item)
   );

   ctfe_back #(
      .LOW_TAPS (LOW_TAPS),
      .MID_TAPS (MID_TAPS),
      .HIGH_TAPS(HIGH_TAPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule
